### sv/lseg_pkg.sv
// shared types, constants and register codes for the led strip effect generator
// no dependencies; used by every module of the block
package lseg_pkg;

    localparam int PIX_W     = 6;
    localparam int COLOR_W   = 8;
    localparam int MODE_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int PHASE_W   = 32;
    localparam int MS_W      = 32;
    localparam int STROBE_W  = 7;
    localparam int THRESH_W  = 9;

    localparam int PIXEL_COUNT_DEF = 60;
    localparam int SINE_DEPTH_DEF  = 1024;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [PHASE_W-1:0]  PULSE_STEP  = 32'd1367131;
    localparam logic [PHASE_W-1:0]  FADE_STEP   = 32'd683565;
    localparam logic [STROBE_W-1:0] STROBE_LAST = 7'd99;
    localparam logic [THRESH_W-1:0] SPEED_BASE  = 9'd260;

    localparam logic [CFG_IDX_W-1:0] REG_RED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED = 3'd4;

    localparam logic [MODE_W-1:0] MODE_SOLID   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RAINBOW = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PULSE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FADE    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STROBE  = 3'd4;

    localparam logic [COLOR_W-1:0] RED_RESET   = 8'd255;
    localparam logic [COLOR_W-1:0] GREEN_RESET = 8'd0;
    localparam logic [COLOR_W-1:0] BLUE_RESET  = 8'd0;
    localparam logic [COLOR_W-1:0] SPEED_RESET = 8'd50;

    typedef enum logic [1:0] {
        KIND_FLAT    = 2'd0,
        KIND_RAINBOW = 2'd1,
        KIND_SINE    = 2'd2
    } t_kind;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        t_kind              kind;
        t_rgb               color;
        logic [COLOR_W-1:0] offset;
        logic [PHASE_W-1:0] phase;
    } t_frame;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [COLOR_W-1:0]   data;
    } t_cfg_wr;

endpackage

### sv/led_strip_effect_generator.sv
// top level of the led strip effect generator: front end, frame queue and pixel engine
// depends on lseg_pkg, lseg_front, lseg_queue and lseg_back
//
// Each input item is one millisecond tick (tick = 0 is an idle item). When a frame falls due
// the front end queues a descriptor and the pixel engine sends PIXEL_COUNT pixel items, one
// per cycle while the output side takes them. Solid, rainbow and strobe frames go from the
// queue straight to the emit state; pulse and fade frames first pass through the sine
// sequencer (the table index, the quarter-turn reciprocal multiply, then the polynomial,
// level and scaling multiplies). Two descriptors can wait in the queue; ticks are stalled
// only while it is full. Register writes are taken every cycle.
module led_strip_effect_generator #(
    parameter int PIXEL_COUNT      = lseg_pkg::PIXEL_COUNT_DEF,
    parameter int SINE_TABLE_DEPTH = lseg_pkg::SINE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lseg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lseg_pkg::COLOR_W-1:0]   i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_tick,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [lseg_pkg::PIX_W-1:0]     o_pixel_index,
    output logic [lseg_pkg::COLOR_W-1:0]   o_pixel_red,
    output logic [lseg_pkg::COLOR_W-1:0]   o_pixel_green,
    output logic [lseg_pkg::COLOR_W-1:0]   o_pixel_blue,
    output logic                           o_frame_end
);

    lseg_pkg::t_cfg_wr w_cfg;
    lseg_pkg::t_frame  w_push_frame, w_pop_frame;
    logic              w_push, w_pop, w_full, w_empty;

    assign o_cfg_ready = 1'b1;
    assign w_cfg = '{valid: i_cfg_valid, index: i_cfg_index, data: i_cfg_data};

    lseg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_in_valid (i_in_valid),
        .i_tick     (i_tick),
        .o_in_stall (o_in_stall),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_frame    (w_push_frame)
    );

    lseg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_frame (w_push_frame),
        .i_pop   (w_pop),
        .o_frame (w_pop_frame),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    lseg_back #(
        .PIXEL_COUNT      (PIXEL_COUNT),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_empty),
        .i_frame       (w_pop_frame),
        .o_pop         (w_pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_pixel_index (o_pixel_index),
        .o_pixel_red   (o_pixel_red),
        .o_pixel_green (o_pixel_green),
        .o_pixel_blue  (o_pixel_blue),
        .o_frame_end   (o_frame_end)
    );

`ifndef NO_ASSERTIONS
    a_last_index : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> (o_pixel_index == lseg_pkg::PIX_W'(PIXEL_COUNT - 1)))
        else $error("frame end flag on a pixel other than the last");

    a_pixel_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_frame_end) |=>
        (o_out_valid && o_pixel_index == $past(o_pixel_index) + 6'd1))
        else $error("pixels of a frame not sent back to back in order");

    a_reset_clear : assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("output valid or input stall set after reset");
`endif

endmodule

### sv/lseg_front.sv
// front end: configuration registers, millisecond and phase counters, frame scheduling
// depends on lseg_pkg; hands one frame descriptor per due frame to the queue
module lseg_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lseg_pkg::t_cfg_wr i_cfg,
    input  logic             i_in_valid,
    input  logic             i_tick,
    output logic             o_in_stall,
    input  logic             i_q_full,
    output logic             o_push,
    output lseg_pkg::t_frame o_frame
);

    logic [lseg_pkg::COLOR_W-1:0]  r_red, r_green, r_blue, r_speed;
    logic [lseg_pkg::MODE_W-1:0]   r_mode;
    logic [lseg_pkg::MS_W-1:0]     r_now, r_last, n_now, w_elapsed;
    logic [lseg_pkg::PHASE_W-1:0]  r_pulse, r_fade, n_pulse, n_fade;
    logic [lseg_pkg::STROBE_W-1:0] r_strobe_cnt, n_strobe_cnt;
    logic                          r_strobe_on, n_strobe_on;
    logic [lseg_pkg::COLOR_W-1:0]  r_offset;
    logic [lseg_pkg::THRESH_W-1:0] w_thresh;
    logic                          w_tick, w_due, w_mode_ok;
    lseg_pkg::t_rgb                w_user;

    assign o_in_stall = i_q_full;
    assign w_tick     = i_in_valid && !i_q_full && i_tick;

    assign n_now   = r_now + 32'd1;
    assign n_pulse = r_pulse + lseg_pkg::PULSE_STEP;
    assign n_fade  = r_fade + lseg_pkg::FADE_STEP;

    always_comb begin
        if (r_strobe_cnt >= lseg_pkg::STROBE_LAST) begin
            n_strobe_cnt = '0;
            n_strobe_on  = !r_strobe_on;
        end else begin
            n_strobe_cnt = r_strobe_cnt + 7'd1;
            n_strobe_on  = r_strobe_on;
        end
    end

    assign w_thresh  = lseg_pkg::SPEED_BASE - {1'b0, r_speed};
    assign w_elapsed = n_now - r_last;
    assign w_due     = w_elapsed > {{(lseg_pkg::MS_W - lseg_pkg::THRESH_W){1'b0}}, w_thresh};

    assign w_user = '{red: r_red, green: r_green, blue: r_blue};

    always_comb begin
        w_mode_ok     = 1'b1;
        o_frame.kind  = lseg_pkg::KIND_FLAT;
        o_frame.color = w_user;
        o_frame.offset = r_offset;
        o_frame.phase = n_fade;
        case (r_mode) inside
            lseg_pkg::MODE_SOLID: begin
                o_frame.kind = lseg_pkg::KIND_FLAT;
            end
            lseg_pkg::MODE_RAINBOW: begin
                o_frame.kind = lseg_pkg::KIND_RAINBOW;
            end
            lseg_pkg::MODE_PULSE, lseg_pkg::MODE_FADE: begin
                o_frame.kind  = lseg_pkg::KIND_SINE;
                o_frame.phase = (r_mode == lseg_pkg::MODE_PULSE) ? n_pulse : n_fade;
            end
            lseg_pkg::MODE_STROBE: begin
                o_frame.kind = lseg_pkg::KIND_FLAT;
                if (!n_strobe_on) begin
                    o_frame.color = '0;
                end
            end
            default: begin
                w_mode_ok = 1'b0;
            end
        endcase
    end

    assign o_push = w_tick && w_due && w_mode_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red   <= lseg_pkg::RED_RESET;
            r_green <= lseg_pkg::GREEN_RESET;
            r_blue  <= lseg_pkg::BLUE_RESET;
            r_mode  <= lseg_pkg::MODE_SOLID;
            r_speed <= lseg_pkg::SPEED_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                lseg_pkg::REG_RED:   r_red   <= i_cfg.data;
                lseg_pkg::REG_GREEN: r_green <= i_cfg.data;
                lseg_pkg::REG_BLUE:  r_blue  <= i_cfg.data;
                lseg_pkg::REG_MODE:  r_mode  <= i_cfg.data[lseg_pkg::MODE_W-1:0];
                lseg_pkg::REG_SPEED: r_speed <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now        <= '0;
            r_last       <= '0;
            r_pulse      <= '0;
            r_fade       <= '0;
            r_strobe_cnt <= '0;
            r_strobe_on  <= 1'b1;
            r_offset     <= '0;
        end else if (w_tick) begin
            r_now        <= n_now;
            r_pulse      <= n_pulse;
            r_fade       <= n_fade;
            r_strobe_cnt <= n_strobe_cnt;
            r_strobe_on  <= n_strobe_on;
            if (w_due) begin
                r_last <= n_now;
                if (r_mode == lseg_pkg::MODE_RAINBOW) begin
                    r_offset <= r_offset + 8'd1;
                end
            end
        end
    end

endmodule

### sv/lseg_queue.sv
// short frame descriptor queue between the front end and the pixel engine
// depends on lseg_pkg for the descriptor type and depth
module lseg_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lseg_pkg::t_frame i_frame,
    input  logic             i_pop,
    output lseg_pkg::t_frame o_frame,
    output logic             o_full,
    output logic             o_empty
);

    lseg_pkg::t_frame                r_mem [lseg_pkg::QUEUE_DEPTH];
    logic [lseg_pkg::QUEUE_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [lseg_pkg::QUEUE_AW:0]     r_count;
    logic                            w_push, w_pop;

    assign o_full  = r_count == (lseg_pkg::QUEUE_AW + 1)'(lseg_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_frame = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### sv/lseg_back.sv
// pixel engine: sine level sequencer, color scaling, rainbow wheel and pixel output register
// depends on lseg_pkg; takes frame descriptors from lseg_queue
module lseg_back #(
    parameter int PIXEL_COUNT      = lseg_pkg::PIXEL_COUNT_DEF,
    parameter int SINE_TABLE_DEPTH = lseg_pkg::SINE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_empty,
    input  lseg_pkg::t_frame             i_frame,
    output logic                         o_pop,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic [lseg_pkg::PIX_W-1:0]   o_pixel_index,
    output logic [lseg_pkg::COLOR_W-1:0] o_pixel_red,
    output logic [lseg_pkg::COLOR_W-1:0] o_pixel_green,
    output logic [lseg_pkg::COLOR_W-1:0] o_pixel_blue,
    output logic                         o_frame_end
);

    localparam int KW        = $clog2(SINE_TABLE_DEPTH);
    localparam int DW        = KW + 1;
    localparam int UW        = 18;
    localparam int RSH       = 2 * KW;
    localparam int RW        = UW + KW + 2;
    localparam int REM_W     = lseg_pkg::PIX_W + 1;
    localparam int HUE_Q     = 256 / PIXEL_COUNT;
    localparam int HUE_R     = 256 % PIXEL_COUNT;
    localparam logic [DW-1:0]    DIVISOR  = DW'(SINE_TABLE_DEPTH);
    // reciprocal of the table depth, exact for every index below the depth
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << (UW + RSH)) + 64'(SINE_TABLE_DEPTH) - 64'd1) / 64'(SINE_TABLE_DEPTH);
    localparam logic [RW-1:0]    RECIP    = RW'(RECIP_FULL);
    localparam logic [lseg_pkg::PIX_W-1:0] LAST_PIX = lseg_pkg::PIX_W'(PIXEL_COUNT - 1);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_KIDX  = 11'b00000000010,
        ST_DIV   = 11'b00000000100,
        ST_SQ    = 11'b00000001000,
        ST_INNER = 11'b00000010000,
        ST_MID   = 11'b00000100000,
        ST_SIN   = 11'b00001000000,
        ST_LVL   = 11'b00010000000,
        ST_SCALE = 11'b00100000000,
        ST_NORM  = 11'b01000000000,
        ST_EMIT  = 11'b10000000000
    } t_state;

    function automatic lseg_pkg::t_rgb wheel(input logic [7:0] hue);
        logic [7:0]     w;
        logic [7:0]     w3;
        lseg_pkg::t_rgb c;
        w = 8'd255 - hue;
        if (w < 8'd85) begin
            w3 = 8'({2'b00, w} + {1'b0, w, 1'b0});
            c  = '{red: 8'd255 - w3, green: 8'd0, blue: w3};
        end else if (w < 8'd170) begin
            w  = w - 8'd85;
            w3 = 8'({2'b00, w} + {1'b0, w, 1'b0});
            c  = '{red: 8'd0, green: w3, blue: 8'd255 - w3};
        end else begin
            w  = w - 8'd170;
            w3 = 8'({2'b00, w} + {1'b0, w, 1'b0});
            c  = '{red: w3, green: 8'd255 - w3, blue: 8'd0};
        end
        return c;
    endfunction

    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [15:0] sum;
        sum = x + {8'd0, x[15:8]} + 16'd1;
        return sum[15:8];
    endfunction

    t_state                        r_state, n_state;
    lseg_pkg::t_frame              r_frame;
    lseg_pkg::t_rgb                r_color;
    logic [KW-1:0]                 r_k;
    logic [UW-1:0]                 r_quo;
    logic [16:0]                   r_z, r_z2, r_mid;
    logic [15:0]                   r_inner;
    logic [17:0]                   r_s;
    logic [7:0]                    r_lvl;
    logic [15:0]                   r_prod_r, r_prod_g, r_prod_b;
    logic [lseg_pkg::PIX_W-1:0]    r_pix;
    logic [7:0]                    r_hue_base;
    logic [REM_W-1:0]              r_hue_rem;

    logic [lseg_pkg::PHASE_W+DW-1:0] w_kprod;
    logic [KW+RW-1:0]              w_uprod;
    logic [16:0]                   w_z;
    logic [33:0]                   w_zz, w_zmid;
    logic [29:0]                   w_c4640;
    logic [32:0]                   w_z2inner;
    logic [18:0]                   w_base;
    logic [25:0]                   w_lvl_prod;
    logic                          w_load, w_last;
    logic [7:0]                    w_hue;
    logic [REM_W-1:0]              w_rem_sum;
    lseg_pkg::t_rgb                w_wheel;

    assign o_pop  = (r_state == ST_IDLE) && !i_q_empty;
    assign w_load = (r_state == ST_EMIT) && (!o_out_valid || !i_out_stall);
    assign w_last = r_pix == LAST_PIX;

    assign w_kprod    = r_frame.phase * DIVISOR;
    assign w_uprod    = r_k * RECIP;
    assign w_z        = r_quo[16] ? (17'd65536 - {1'b0, r_quo[15:0]}) : {1'b0, r_quo[15:0]};
    assign w_zz       = w_z * w_z;
    assign w_c4640    = 13'd4640 * r_z2;
    assign w_z2inner  = r_z2 * r_inner;
    assign w_zmid     = r_z * r_mid;
    assign w_base     = r_quo[17] ? (19'd65536 - {1'b0, r_s}) : (19'd65536 + {1'b0, r_s});
    assign w_lvl_prod = w_base * 7'd127;

    assign w_hue     = r_hue_base + r_frame.offset;
    assign w_wheel   = wheel(w_hue);
    assign w_rem_sum = r_hue_rem + REM_W'(HUE_R);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    n_state = (i_frame.kind == lseg_pkg::KIND_SINE) ? ST_KIDX : ST_EMIT;
                end
            end
            ST_KIDX:  n_state = ST_DIV;
            ST_DIV:   n_state = ST_SQ;
            ST_SQ:    n_state = ST_INNER;
            ST_INNER: n_state = ST_MID;
            ST_MID:   n_state = ST_SIN;
            ST_SIN:   n_state = ST_LVL;
            ST_LVL:   n_state = ST_SCALE;
            ST_SCALE: n_state = ST_NORM;
            ST_NORM:  n_state = ST_EMIT;
            ST_EMIT: begin
                if (w_load && w_last) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_frame    <= i_frame;
                r_color    <= i_frame.color;
                r_pix      <= '0;
                r_hue_base <= '0;
                r_hue_rem  <= '0;
            end
            ST_KIDX:  r_k   <= w_kprod[lseg_pkg::PHASE_W +: KW];
            ST_DIV:   r_quo <= w_uprod[RSH +: UW];
            ST_SQ: begin
                r_z  <= w_z;
                r_z2 <= w_zz[32:16];
            end
            ST_INNER: r_inner <= 16'd42048 - {2'b00, w_c4640[29:16]};
            ST_MID:   r_mid   <= 17'd102944 - w_z2inner[32:16];
            ST_SIN:   r_s     <= w_zmid[33:16];
            ST_LVL:   r_lvl   <= w_lvl_prod[23:16];
            ST_SCALE: begin
                r_prod_r <= r_frame.color.red * r_lvl;
                r_prod_g <= r_frame.color.green * r_lvl;
                r_prod_b <= r_frame.color.blue * r_lvl;
            end
            ST_NORM: begin
                r_color <= '{red: div255(r_prod_r), green: div255(r_prod_g),
                             blue: div255(r_prod_b)};
            end
            ST_EMIT: begin
                if (w_load) begin
                    r_pix <= r_pix + 1'b1;
                    if (w_rem_sum >= REM_W'(PIXEL_COUNT)) begin
                        r_hue_rem  <= w_rem_sum - REM_W'(PIXEL_COUNT);
                        r_hue_base <= r_hue_base + 8'(HUE_Q + 1);
                    end else begin
                        r_hue_rem  <= w_rem_sum;
                        r_hue_base <= r_hue_base + 8'(HUE_Q);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_pixel_index <= r_pix;
            o_frame_end   <= w_last;
            if (r_frame.kind == lseg_pkg::KIND_RAINBOW) begin
                o_pixel_red   <= w_wheel.red;
                o_pixel_green <= w_wheel.green;
                o_pixel_blue  <= w_wheel.blue;
            end else begin
                o_pixel_red   <= r_color.red;
                o_pixel_green <= r_color.green;
                o_pixel_blue  <= r_color.blue;
            end
        end
    end

endmodule
